FILE: hw/rtl/xcs_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM-CRC sender package
// Shared widths, protocol bytes, command codes and the CRC byte update.
// ----------------------------------------------------------------------------
package xcs_pkg;

  // Packet geometry.
  localparam int PACKET_BYTES = 128;
  localparam int PKT_AW       = $clog2(PACKET_BYTES);

  localparam logic [7:0] PKT_LEN    = 8'(PACKET_BYTES);
  localparam logic [7:0] HDR_LEN    = 8'd3;
  localparam logic [7:0] CRC_HI_IDX = 8'(PACKET_BYTES + 3);
  localparam logic [7:0] FRAME_LAST = 8'(PACKET_BYTES + 4);

  // Configuration port.
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] CFG_START_TIMEOUT = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_ACK_TIMEOUT   = 1'b1;
  localparam logic [15:0] START_TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] ACK_TIMEOUT_RESET   = 16'd2000;

  // Request commands.
  localparam logic [2:0] CMD_IMAGE = 3'd0;
  localparam logic [2:0] CMD_RX    = 3'd1;
  localparam logic [2:0] CMD_TICK  = 3'd2;
  localparam logic [2:0] CMD_SLOT  = 3'd3;
  localparam logic [2:0] CMD_END   = 3'd4;

  // Link bytes.
  localparam logic [7:0] BYTE_SOH   = 8'h01;
  localparam logic [7:0] BYTE_EOT   = 8'h04;
  localparam logic [7:0] BYTE_ACK   = 8'h06;
  localparam logic [7:0] BYTE_NAK   = 8'h15;
  localparam logic [7:0] BYTE_PAD   = 8'h1A;
  localparam logic [7:0] BYTE_START = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int n = 0; n < 8; n++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/xcs_if.sv
// ----------------------------------------------------------------------------
// XMODEM-CRC sender channels
// Valid/ready request channel and result channel with their payloads.
// ----------------------------------------------------------------------------
interface xcs_in_if import xcs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] byte_value;

  modport source (output valid, command, byte_value, input ready);
  modport sink   (input valid, command, byte_value, output ready);
endinterface

interface xcs_out_if import xcs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [2:0]  phase;
  logic        refused;
  logic [15:0] packets_sent;
  logic        done_res;

  modport source (output valid, tx_valid, tx_byte, phase, refused, packets_sent,
                  done_res, input ready);
  modport sink   (input valid, tx_valid, tx_byte, phase, refused, packets_sent,
                  done_res, output ready);
endinterface

FILE: hw/rtl/xcs_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module xcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/xmodem_crc_sender_unit.sv
// ----------------------------------------------------------------------------
// XMODEM-CRC sender
// A result is registered, so it shows in the cycle after its request is accepted.
// Throughput: one request per cycle unless the result is held by the consumer; the
// buffer read uses the next send index, so each slot finds its data byte waiting.
// Reset: synchronous, active low; timeouts return to 5000 and 2000 ticks and
// the packet buffer is not cleared, since only bytes of the current fill are read.
// ----------------------------------------------------------------------------
module xmodem_crc_sender_unit import xcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  xcs_in_if.sink            in_ch,
  xcs_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_WAIT_START   = 3'd0,
    PH_FILL         = 3'd1,
    PH_SEND         = 3'd2,
    PH_WAIT_ACK     = 3'd3,
    PH_SEND_EOT     = 3'd4,
    PH_WAIT_EOT_ACK = 3'd5,
    PH_DONE         = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [7:0]  send_r, send_nxt;
  logic [7:0]  block_r, block_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        ended_r, ended_nxt;
  logic [15:0] sent_r, sent_nxt;
  logic [15:0] start_to_r, ack_to_r;

  logic        out_valid_r;
  logic        tx_valid_r, refused_r, done_r;
  logic [7:0]  tx_byte_r;
  logic [2:0]  phase_out_r;
  logic [15:0] packets_r;

  logic        accept;
  logic        txv, refused;
  logic [7:0]  txb;
  logic        ram_we;
  logic [7:0]  ram_rdata;
  logic [7:0]  data_k, rd_k, data_byte;
  logic [15:0] tick_inc;

  // The output register is free or is being emptied this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Packet buffer: written during fill, read one slot ahead during send.
  assign rd_k = send_nxt - HDR_LEN;

  xcs_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[PKT_AW-1:0]),
    .wdata (in_ch.byte_value),
    .raddr (rd_k[PKT_AW-1:0]),
    .rdata (ram_rdata)
  );

  // Data byte for the current slot, padded beyond the filled part.
  assign data_k    = send_r - HDR_LEN;
  assign data_byte = (data_k < fill_r) ? ram_rdata : BYTE_PAD;
  assign tick_inc  = (tick_r != TICK_MAX) ? tick_r + 16'd1 : tick_r;

  // Next state for one request.
  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    send_nxt  = send_r;
    block_nxt = block_r;
    crc_nxt   = crc_r;
    tick_nxt  = tick_r;
    ended_nxt = ended_r;
    sent_nxt  = sent_r;
    ram_we    = 1'b0;
    txv       = 1'b0;
    txb       = 8'h00;
    refused   = 1'b0;
    if (accept) begin
      case (in_ch.command)
        CMD_IMAGE: begin
          if (phase_r != PH_FILL || fill_r >= PKT_LEN) begin
            refused = 1'b1;
          end else begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + 8'd1;
            if (fill_nxt >= PKT_LEN) begin
              phase_nxt = PH_SEND;
              send_nxt  = 8'd0;
              crc_nxt   = 16'd0;
            end
          end
        end
        CMD_END: begin
          if (phase_r != PH_FILL) begin
            refused = 1'b1;
          end else begin
            ended_nxt = 1'b1;
            if (fill_r == 8'd0) begin
              phase_nxt = PH_SEND_EOT;
            end else begin
              phase_nxt = PH_SEND;
              send_nxt  = 8'd0;
              crc_nxt   = 16'd0;
            end
          end
        end
        CMD_RX: begin
          if (phase_r == PH_WAIT_START) begin
            if (in_ch.byte_value == BYTE_START) begin
              phase_nxt = PH_FILL;
            end
          end else if (phase_r == PH_WAIT_ACK) begin
            if (in_ch.byte_value == BYTE_ACK) begin
              block_nxt = block_r + 8'd1;
              sent_nxt  = (sent_r != TICK_MAX) ? sent_r + 16'd1 : sent_r;
              fill_nxt  = 8'd0;
              phase_nxt = ended_r ? PH_SEND_EOT : PH_FILL;
            end else if (in_ch.byte_value == BYTE_NAK) begin
              phase_nxt = PH_SEND;
              send_nxt  = 8'd0;
              crc_nxt   = 16'd0;
            end
          end else if (phase_r == PH_WAIT_EOT_ACK) begin
            if (in_ch.byte_value == BYTE_ACK) begin
              phase_nxt = PH_DONE;
            end else if (in_ch.byte_value == BYTE_NAK) begin
              phase_nxt = PH_SEND_EOT;
            end
          end
        end
        CMD_TICK: begin
          if (phase_r == PH_WAIT_START) begin
            tick_nxt = tick_inc;
            if (tick_inc >= start_to_r) begin
              phase_nxt = PH_FILL;
            end
          end else if (phase_r == PH_WAIT_ACK) begin
            tick_nxt = tick_inc;
            if (tick_inc >= ack_to_r) begin
              block_nxt = block_r + 8'd1;
              sent_nxt  = (sent_r != TICK_MAX) ? sent_r + 16'd1 : sent_r;
              fill_nxt  = 8'd0;
              phase_nxt = ended_r ? PH_SEND_EOT : PH_FILL;
            end
          end
        end
        CMD_SLOT: begin
          if (phase_r == PH_SEND) begin
            txv = 1'b1;
            if (send_r == 8'd0) begin
              txb = BYTE_SOH;
            end else if (send_r == 8'd1) begin
              txb = block_r;
            end else if (send_r == 8'd2) begin
              txb = ~block_r;
            end else if (send_r < CRC_HI_IDX) begin
              txb     = data_byte;
              crc_nxt = crc_byte(crc_r, data_byte);
            end else if (send_r == CRC_HI_IDX) begin
              txb = crc_r[15:8];
            end else begin
              txb = crc_r[7:0];
            end
            if (send_r >= FRAME_LAST) begin
              phase_nxt = PH_WAIT_ACK;
              tick_nxt  = 16'd0;
              send_nxt  = 8'd0;
            end else begin
              send_nxt = send_r + 8'd1;
            end
          end else if (phase_r == PH_SEND_EOT) begin
            txv       = 1'b1;
            txb       = BYTE_EOT;
            phase_nxt = PH_WAIT_EOT_ACK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State, configuration and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_START;
      fill_r      <= 8'd0;
      send_r      <= 8'd0;
      block_r     <= 8'd1;
      crc_r       <= 16'd0;
      tick_r      <= 16'd0;
      ended_r     <= 1'b0;
      sent_r      <= 16'd0;
      start_to_r  <= START_TIMEOUT_RESET;
      ack_to_r    <= ACK_TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      send_r  <= send_nxt;
      block_r <= block_nxt;
      crc_r   <= crc_nxt;
      tick_r  <= tick_nxt;
      ended_r <= ended_nxt;
      sent_r  <= sent_nxt;
      if (cfg_we) begin
        if (cfg_addr == CFG_START_TIMEOUT) begin
          start_to_r <= cfg_data;
        end else if (cfg_addr == CFG_ACK_TIMEOUT) begin
          ack_to_r <= cfg_data;
        end
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      tx_valid_r  <= txv;
      tx_byte_r   <= txb;
      phase_out_r <= phase_nxt;
      refused_r   <= refused;
      packets_r   <= sent_nxt;
      done_r      <= (phase_nxt == PH_DONE);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tx_valid     = tx_valid_r;
  assign out_ch.tx_byte      = tx_byte_r;
  assign out_ch.phase        = phase_out_r;
  assign out_ch.refused      = refused_r;
  assign out_ch.packets_sent = packets_r;
  assign out_ch.done_res     = done_r;

endmodule
